>>> rtl/gpat_pkg.sv
`default_nettype none
package gpat_pkg;

   localparam int PATCH_SLOTS       = 8;
   localparam int MEMBERS_PER_PATCH = 8;
   localparam int MEMBER_SLOTS      = PATCH_SLOTS * MEMBERS_PER_PATCH;
   localparam int MAX_OUT           = 64;

   localparam int GW  = 16;
   localparam int TW  = 32;
   localparam int PW  = (PATCH_SLOTS > 1) ? $clog2(PATCH_SLOTS) : 1;
   localparam int PCW = $clog2(PATCH_SLOTS + 1);
   localparam int MW  = $clog2(MEMBERS_PER_PATCH);
   localparam int MCW = $clog2(MEMBERS_PER_PATCH + 1);
   localparam int AW  = $clog2(MEMBER_SLOTS);
   localparam int KW  = $clog2(MAX_OUT + 1);

   localparam logic [GW-1:0] TIMEOUT_RESET = 16'd10;

   typedef enum logic [1:0] {
      OP_UPDATE,
      OP_DELETE,
      OP_EXPIRE,
      OP_QUERY
   } op_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_NOMATCH,
      ST_TABLE_FULL,
      ST_MEMBER_FULL
   } status_type;

   typedef enum logic [4:0] {
      C_NONE,
      C_LOAD,
      C_FIND,
      C_NEXT_ID,
      C_SCAN_BEGIN,
      C_SCAN,
      C_APPLY,
      C_ESCAN,
      C_EFIN,
      C_HSCAN,
      C_PSB,
      C_PSEL,
      C_PTAKE,
      C_MSCAN,
      C_MTAKE,
      C_QFIN,
      C_RESP
   } cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIND,
      S_ID,
      S_SCAN,
      S_APPLY,
      S_ESCAN,
      S_EFIN,
      S_HSCAN,
      S_PSB,
      S_PSEL,
      S_PTAKE,
      S_MSCAN,
      S_MTAKE,
      S_QFIN,
      S_RESP
   } state_type;

   typedef struct packed {
      logic find_fail;
      logic id_zero;
      logic id_last;
      logic pscan_done;
      logic ascan_done;
      logic psel_done;
      logic best_vld;
      logic mem_vld;
      logic k_cap;
   } dp_status_type;

   function automatic logic [AW-1:0] maddr(input logic [PW-1:0] p, input logic [MW-1:0] m);
      return AW'(int'(p) * MEMBERS_PER_PATCH + int'(m));
   endfunction

endpackage
`default_nettype wire

>>> rtl/gpat_ctrl.sv
`default_nettype none
module gpat_ctrl import gpat_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [1:0]    req_op,
   input  wire dp_status_type stat,
   output logic               busy,
   output cmd_type            cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (op_type'(req_op))
                  OP_UPDATE, OP_DELETE: state_in = S_FIND;
                  OP_EXPIRE:            state_in = S_ESCAN;
                  default:              state_in = S_HSCAN;
               endcase
            end
         end
         S_FIND:  state_in = stat.find_fail ? S_RESP : S_ID;
         S_ID: begin
            if (!stat.id_zero) begin
               state_in = S_SCAN;
            end else if (stat.id_last) begin
               state_in = S_RESP;
            end
         end
         S_SCAN:  if (stat.pscan_done) state_in = S_APPLY;
         S_APPLY: state_in = stat.id_last ? S_RESP : S_ID;
         S_ESCAN: if (stat.ascan_done) state_in = S_EFIN;
         S_EFIN:  state_in = S_RESP;
         S_HSCAN: if (stat.ascan_done) state_in = S_PSB;
         S_PSB:   state_in = S_PSEL;
         S_PSEL:  if (stat.psel_done) state_in = S_PTAKE;
         S_PTAKE: state_in = stat.best_vld ? S_MSCAN : S_QFIN;
         S_MSCAN: if (stat.pscan_done) state_in = S_MTAKE;
         S_MTAKE: begin
            if (!stat.mem_vld) begin
               state_in = S_PSB;
            end else begin
               state_in = stat.k_cap ? S_QFIN : S_MSCAN;
            end
         end
         S_QFIN:  state_in = S_IDLE;
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd  = C_NONE;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE:  if (start) cmd = C_LOAD;
         S_FIND:  cmd = C_FIND;
         S_ID: begin
            if (!stat.id_zero) begin
               cmd = C_SCAN_BEGIN;
            end else if (!stat.id_last) begin
               cmd = C_NEXT_ID;
            end
         end
         S_SCAN:  if (!stat.pscan_done) cmd = C_SCAN;
         S_APPLY: cmd = C_APPLY;
         S_ESCAN: if (!stat.ascan_done) cmd = C_ESCAN;
         S_EFIN:  cmd = C_EFIN;
         S_HSCAN: if (!stat.ascan_done) cmd = C_HSCAN;
         S_PSB:   cmd = C_PSB;
         S_PSEL:  if (!stat.psel_done) cmd = C_PSEL;
         S_PTAKE: if (stat.best_vld) cmd = C_PTAKE;
         S_MSCAN: if (!stat.pscan_done) cmd = C_MSCAN;
         S_MTAKE: if (stat.mem_vld) cmd = C_MTAKE;
         S_QFIN:  cmd = C_QFIN;
         S_RESP:  cmd = C_RESP;
         default: cmd = C_NONE;
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/gpat_datapath.sv
`default_nettype none
module gpat_datapath import gpat_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cmd_type         cmd,
   output dp_status_type        stat,
   input  wire logic [1:0]      req_op,
   input  wire logic [GW-1:0]   req_supergroup,
   input  wire logic [GW-1:0]   req_member_one,
   input  wire logic [GW-1:0]   req_member_two,
   input  wire logic [GW-1:0]   req_member_three,
   input  wire logic [GW-1:0]   req_query_group,
   input  wire logic [TW-1:0]   req_now_seconds,
   input  wire logic            csr_write_en,
   input  wire logic [GW-1:0]   csr_stale_timeout,
   output logic                 rsp_strobe,
   output logic [1:0]           rsp_status,
   output logic [GW-1:0]        rsp_group_id,
   output logic                 rsp_last
);

   // latched item
   op_type          op_ff, op_in;
   logic [GW-1:0]   sg_ff, sg_in;
   logic [GW-1:0]   g_ff [3];
   logic [GW-1:0]   g_in [3];
   logic [GW-1:0]   q_ff, q_in;
   logic [TW-1:0]   now_ff, now_in;
   logic [GW-1:0]   tmo_ff, tmo_in;

   // table state
   logic [PATCH_SLOTS-1:0]  pin_ff, pin_in;
   logic [GW-1:0]           pk_ff [PATCH_SLOTS];
   logic [GW-1:0]           pk_in [PATCH_SLOTS];
   logic [MEMBER_SLOTS-1:0] min_ff, min_in;
   logic [GW-1:0]           mg_mem [MEMBER_SLOTS];
   logic [TW-1:0]           ms_mem [MEMBER_SLOTS];
   logic [GW-1:0]           mg_rd_ff;
   logic [TW-1:0]           ms_rd_ff;

   // working registers
   status_type              st_ff, st_in;
   logic [PW-1:0]           p_ff, p_in;
   logic [1:0]              idn_ff, idn_in;
   logic [MCW-1:0]          scm_ff, scm_in;
   logic [PCW-1:0]          scp_ff, scp_in;
   logic                    rv_ff, rv_in;
   logic [PW-1:0]           rp_ff, rp_in;
   logic [MW-1:0]           rm_ff, rm_in;
   logic [AW-1:0]           ri_ff, ri_in;
   logic                    mt_ff, mt_in;
   logic [AW-1:0]           mi_ff, mi_in;
   logic [PATCH_SLOTS-1:0]  keep_ff, keep_in;
   logic [PATCH_SLOTS-1:0]  hit_ff, hit_in;
   logic                    bv_ff, bv_in;
   logic [GW-1:0]           bk_ff, bk_in;
   logic [PW-1:0]           best_ff, best_in;
   logic [MEMBERS_PER_PATCH-1:0] rem_ff, rem_in;
   logic                    mv_ff, mv_in;
   logic [GW-1:0]           mval_ff, mval_in;
   logic [MW-1:0]           mb_ff, mb_in;
   logic                    pend_vld_ff, pend_vld_in;
   logic [GW-1:0]           pend_ff, pend_in;
   logic [KW-1:0]           k_ff, k_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [GW-1:0]           rsp_group_ff, rsp_group_in;
   logic                    rsp_last_ff, rsp_last_in;

   // combinational helpers
   logic                    found, has_free, mfree, issue, all_mode;
   logic [PW-1:0]           fidx, fr, ip, pc;
   logic [MW-1:0]           mfidx, im;
   logic [AW-1:0]           ra, wa;
   logic [GW-1:0]           cur_id;
   logic [TW-1:0]           age;
   logic [MEMBERS_PER_PATCH-1:0] pslice;
   logic                    mg_we, ms_we;

   always_comb begin
      found    = 1'b0;
      fidx     = '0;
      has_free = 1'b0;
      fr       = '0;
      for (int p = PATCH_SLOTS - 1; p >= 0; p--) begin
         if (pin_ff[p] && pk_ff[p] == sg_ff) begin
            found = 1'b1;
            fidx  = PW'(p);
         end
         if (!pin_ff[p]) begin
            has_free = 1'b1;
            fr       = PW'(p);
         end
      end
   end

   always_comb begin
      pslice = min_ff[int'(p_ff) * MEMBERS_PER_PATCH +: MEMBERS_PER_PATCH];
      mfree  = 1'b0;
      mfidx  = '0;
      for (int m = MEMBERS_PER_PATCH - 1; m >= 0; m--) begin
         if (!pslice[m]) begin
            mfree = 1'b1;
            mfidx = MW'(m);
         end
      end
   end

   always_comb begin
      case (idn_ff)
         2'd0:    cur_id = sg_ff;
         2'd1:    cur_id = g_ff[0];
         2'd2:    cur_id = g_ff[1];
         default: cur_id = g_ff[2];
      endcase
   end

   // scan address
   always_comb begin
      all_mode = (cmd == C_ESCAN) || (cmd == C_HSCAN);
      im       = scm_ff[MW-1:0];
      if (all_mode) begin
         ip    = scp_ff[PW-1:0];
         issue = (scp_ff < PCW'(PATCH_SLOTS));
      end else begin
         ip    = p_ff;
         issue = ((cmd == C_SCAN) || (cmd == C_MSCAN)) && (scm_ff < MCW'(MEMBERS_PER_PATCH));
      end
      ra  = maddr(ip, im);
      pc  = scp_ff[PW-1:0];
      age = now_ff - ms_rd_ff;
      wa  = mt_ff ? mi_ff : maddr(p_ff, mfidx);
   end

   always_comb begin
      stat.find_fail  = (op_ff == OP_UPDATE) ? (!found && !has_free) : !found;
      stat.id_zero    = (cur_id == '0);
      stat.id_last    = (idn_ff == 2'd3);
      stat.pscan_done = (scm_ff == MCW'(MEMBERS_PER_PATCH)) && !rv_ff;
      stat.ascan_done = (scp_ff == PCW'(PATCH_SLOTS)) && !rv_ff;
      stat.psel_done  = (scp_ff == PCW'(PATCH_SLOTS));
      stat.best_vld   = bv_ff;
      stat.mem_vld    = mv_ff;
      stat.k_cap      = (k_ff == KW'(MAX_OUT - 1));
   end

   always_comb begin
      op_in   = op_ff;
      sg_in   = sg_ff;
      g_in    = g_ff;
      q_in    = q_ff;
      now_in  = now_ff;
      tmo_in  = csr_write_en ? csr_stale_timeout : tmo_ff;
      pin_in  = pin_ff;
      pk_in   = pk_ff;
      min_in  = min_ff;
      st_in   = st_ff;
      p_in    = p_ff;
      idn_in  = idn_ff;
      scm_in  = scm_ff;
      scp_in  = scp_ff;
      rv_in   = 1'b0;
      rp_in   = ip;
      rm_in   = im;
      ri_in   = ra;
      mt_in   = mt_ff;
      mi_in   = mi_ff;
      keep_in = keep_ff;
      hit_in  = hit_ff;
      bv_in   = bv_ff;
      bk_in   = bk_ff;
      best_in = best_ff;
      rem_in  = rem_ff;
      mv_in   = mv_ff;
      mval_in = mval_ff;
      mb_in   = mb_ff;
      pend_vld_in   = pend_vld_ff;
      pend_in       = pend_ff;
      k_in          = k_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_group_in  = rsp_group_ff;
      rsp_last_in   = rsp_last_ff;
      mg_we = 1'b0;
      ms_we = 1'b0;

      // scan counters
      if (issue) begin
         rv_in = 1'b1;
         if (all_mode && scm_ff == MCW'(MEMBERS_PER_PATCH - 1)) begin
            scm_in = '0;
            scp_in = scp_ff + PCW'(1);
         end else begin
            scm_in = scm_ff + MCW'(1);
         end
      end

      case (cmd)
         C_LOAD: begin
            op_in    = op_type'(req_op);
            sg_in    = req_supergroup;
            g_in[0]  = req_member_one;
            g_in[1]  = req_member_two;
            g_in[2]  = req_member_three;
            q_in     = req_query_group;
            now_in   = req_now_seconds;
            st_in    = ST_OK;
            scm_in   = '0;
            scp_in   = '0;
            keep_in  = '0;
            hit_in   = '0;
            k_in     = '0;
            pend_vld_in = 1'b0;
         end
         C_FIND: begin
            idn_in = (op_ff == OP_UPDATE) ? 2'd0 : 2'd1;
            if (found) begin
               p_in = fidx;
            end else if (op_ff == OP_UPDATE && has_free) begin
               p_in       = fr;
               pin_in[fr] = 1'b1;
               pk_in[fr]  = sg_ff;
               min_in[int'(fr) * MEMBERS_PER_PATCH +: MEMBERS_PER_PATCH] = '0;
            end else begin
               st_in = (op_ff == OP_UPDATE) ? ST_TABLE_FULL : ST_NOMATCH;
            end
         end
         C_NEXT_ID: idn_in = idn_ff + 2'd1;
         C_SCAN_BEGIN: begin
            scm_in = '0;
            mt_in  = 1'b0;
         end
         C_SCAN: begin
            if (rv_ff && min_ff[ri_ff] && mg_rd_ff == cur_id) begin
               mt_in = 1'b1;
               mi_in = ri_ff;
            end
         end
         C_APPLY: begin
            idn_in = idn_ff + 2'd1;
            if (op_ff == OP_UPDATE) begin
               if (mt_ff) begin
                  ms_we = 1'b1;
               end else if (mfree) begin
                  mg_we      = 1'b1;
                  ms_we      = 1'b1;
                  min_in[wa] = 1'b1;
               end else begin
                  st_in = ST_MEMBER_FULL;
               end
            end else if (mt_ff) begin
               min_in[mi_ff] = 1'b0;
            end
         end
         C_ESCAN: begin
            if (rv_ff && pin_ff[rp_ff] && min_ff[ri_ff]) begin
               if (age >= {{(TW-GW){1'b0}}, tmo_ff}) begin
                  min_in[ri_ff] = 1'b0;
               end else begin
                  keep_in[rp_ff] = 1'b1;
               end
            end
         end
         C_EFIN: pin_in = pin_ff & keep_ff;
         C_HSCAN: begin
            if (rv_ff && pin_ff[rp_ff] && min_ff[ri_ff] && mg_rd_ff == q_ff) begin
               hit_in[rp_ff] = 1'b1;
            end
         end
         C_PSB: begin
            scp_in = '0;
            bv_in  = 1'b0;
         end
         C_PSEL: begin
            scp_in = scp_ff + PCW'(1);
            if (hit_ff[pc] && (!bv_ff || pk_ff[pc] < bk_ff)) begin
               bv_in   = 1'b1;
               bk_in   = pk_ff[pc];
               best_in = pc;
            end
         end
         C_PTAKE: begin
            hit_in[best_ff] = 1'b0;
            p_in   = best_ff;
            rem_in = min_ff[int'(best_ff) * MEMBERS_PER_PATCH +: MEMBERS_PER_PATCH];
            scm_in = '0;
            mv_in  = 1'b0;
         end
         C_MSCAN: begin
            if (rv_ff && rem_ff[rm_ff] && (!mv_ff || mg_rd_ff < mval_ff)) begin
               mv_in   = 1'b1;
               mval_in = mg_rd_ff;
               mb_in   = rm_ff;
            end
         end
         C_MTAKE: begin
            rem_in[mb_ff] = 1'b0;
            if (pend_vld_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_OK;
               rsp_group_in  = pend_ff;
               rsp_last_in   = 1'b0;
            end
            pend_vld_in = 1'b1;
            pend_in     = mval_ff;
            k_in        = k_ff + KW'(1);
            scm_in      = '0;
            mv_in       = 1'b0;
         end
         C_QFIN: begin
            rsp_strobe_in = 1'b1;
            rsp_last_in   = 1'b1;
            rsp_status_in = pend_vld_ff ? ST_OK : ST_NOMATCH;
            rsp_group_in  = pend_vld_ff ? pend_ff : '0;
         end
         C_RESP: begin
            rsp_strobe_in = 1'b1;
            rsp_last_in   = 1'b1;
            rsp_status_in = st_ff;
            rsp_group_in  = '0;
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tmo_ff        <= TIMEOUT_RESET;
         pin_ff        <= '0;
         min_ff        <= '0;
         rv_ff         <= 1'b0;
         pend_vld_ff   <= 1'b0;
         k_ff          <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         tmo_ff        <= tmo_in;
         pin_ff        <= pin_in;
         min_ff        <= min_in;
         rv_ff         <= rv_in;
         pend_vld_ff   <= pend_vld_in;
         k_ff          <= k_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      sg_ff   <= sg_in;
      g_ff    <= g_in;
      q_ff    <= q_in;
      now_ff  <= now_in;
      pk_ff   <= pk_in;
      st_ff   <= st_in;
      p_ff    <= p_in;
      idn_ff  <= idn_in;
      scm_ff  <= scm_in;
      scp_ff  <= scp_in;
      rp_ff   <= rp_in;
      rm_ff   <= rm_in;
      ri_ff   <= ri_in;
      mt_ff   <= mt_in;
      mi_ff   <= mi_in;
      keep_ff <= keep_in;
      hit_ff  <= hit_in;
      bv_ff   <= bv_in;
      bk_ff   <= bk_in;
      best_ff <= best_in;
      rem_ff  <= rem_in;
      mv_ff   <= mv_in;
      mval_ff <= mval_in;
      mb_ff   <= mb_in;
      pend_ff <= pend_in;
      rsp_status_ff <= rsp_status_in;
      rsp_group_ff  <= rsp_group_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // member store
   always_ff @(posedge clock) begin
      if (mg_we) begin
         mg_mem[wa] <= cur_id;
      end
      if (ms_we) begin
         ms_mem[wa] <= now_ff;
      end
      mg_rd_ff <= mg_mem[ra];
      ms_rd_ff <= ms_mem[ra];
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_group_id = rsp_group_ff;
   assign rsp_last     = rsp_last_ff;

   a_pend_counted: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (k_ff != '0))
      else $error("pending item without count");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      k_ff <= KW'(MAX_OUT))
      else $error("listing count past cap");

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd == C_LOAD) |=> (!pend_vld_ff && k_ff == '0))
      else $error("listing state not cleared on load");

   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_last_ff) |-> (rsp_status_ff == ST_OK && rsp_group_ff != '0))
      else $error("bad intermediate listing item");

endmodule
`default_nettype wire

>>> rtl/group_patch_aging_table.sv
`default_nettype none
// Patch table with member aging. An item is taken when start is high and busy is low;
// busy stays high until the item's last result has been issued. Results come out one
// per cycle-marked rsp_strobe pulse and cannot be stalled; rsp_last flags the final one.
// Every member visit goes through the member store's single read port, one slot per
// cycle. Update and delete scan the matched patch's member slots once per nonzero id;
// expire scans every member slot; query does too, then lists matching patches in key
// order and each one's members in ascending id order (8 patches of 8 members here).
// stale_timeout is written through csr_write_en/csr_stale_timeout; the user must do so
// only while idle, as the block itself does not enforce it.
module group_patch_aging_table import gpat_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire logic [1:0]    req_op,
   input  wire logic [15:0]   req_supergroup,
   input  wire logic [15:0]   req_member_one,
   input  wire logic [15:0]   req_member_two,
   input  wire logic [15:0]   req_member_three,
   input  wire logic [15:0]   req_query_group,
   input  wire logic [31:0]   req_now_seconds,
   input  wire logic          csr_write_en,
   input  wire logic [15:0]   csr_stale_timeout,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_group_id,
   output logic               rsp_last
);

   cmd_type       cmd;
   dp_status_type stat;

   gpat_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_op  (req_op),
      .stat    (stat),
      .busy    (busy),
      .cmd     (cmd)
   );

   gpat_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_op            (req_op),
      .req_supergroup    (req_supergroup),
      .req_member_one    (req_member_one),
      .req_member_two    (req_member_two),
      .req_member_three  (req_member_three),
      .req_query_group   (req_query_group),
      .req_now_seconds   (req_now_seconds),
      .csr_write_en      (csr_write_en),
      .csr_stale_timeout (csr_stale_timeout),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_group_id      (rsp_group_id),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire
